@@ sv/ifp_pkg.sv @@
// Shared types, character codes and helper functions of the infix to postfix converter.
package ifp_pkg;

  localparam int unsigned DEF_STACK_DEPTH = 32;

  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_NUL    = 8'h00;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_OVERFLOW  = 2'd1,
    STAT_UNMATCHED = 2'd2
  } status_t;

  typedef struct packed {
    logic [7:0] in_char;
    logic       end_of_expr;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       last;
    status_t    status;
  } out_word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_READ,
    ST_EVAL,
    ST_PUSH,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic push;
    logic pop;
  } stk_ctrl_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic one_left;
    logic paren_any;
  } stk_stat_t;

  function automatic logic [1:0] op_prio(input logic [7:0] c);
    logic [1:0] p;
    p = 2'd0;
    if (c == CH_PLUS || c == CH_MINUS) p = 2'd1;
    if (c == CH_STAR || c == CH_SLASH) p = 2'd2;
    return p;
  endfunction

  function automatic logic is_alnum(input logic [7:0] c);
    return (c inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A]});
  endfunction

endpackage

@@ sv/ifp_stack.sv @@
// Operator stack: one-port memory with registered top read, fill count and '(' count.
module ifp_stack import ifp_pkg::*; #(
  parameter int unsigned STACK_DEPTH = DEF_STACK_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  stk_ctrl_t  ctrl,
  input  logic [7:0] push_char,
  output logic [7:0] top_char,
  output stk_stat_t  stat
);

  localparam int unsigned AW = $clog2(STACK_DEPTH);
  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);

  logic [7:0]    mem [STACK_DEPTH];
  logic [CW-1:0] count;
  logic [CW-1:0] paren;
  logic [CW-1:0] count_dec;
  logic [AW-1:0] top_addr;
  logic [AW-1:0] wr_addr;

  assign count_dec = count - CW'(1);
  assign top_addr  = count_dec[AW-1:0];
  assign wr_addr   = count[AW-1:0];

  // top is re-read every cycle; only used once it has been read with the count steady
  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      mem[wr_addr] <= push_char;
    end
    top_char <= mem[top_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      paren <= '0;
    end else begin
      if (ctrl.push) begin
        count <= count + CW'(1);
        if (push_char == CH_LPAREN) paren <= paren + CW'(1);
      end else if (ctrl.pop) begin
        count <= count_dec;
        if (top_char == CH_LPAREN) paren <= paren - CW'(1);
      end
    end
  end

  assign stat.empty     = (count == '0);
  assign stat.full      = (count == CW'(STACK_DEPTH));
  assign stat.one_left  = (count == CW'(1));
  assign stat.paren_any = (paren != '0);

endmodule

@@ sv/infix_to_postfix_converter_core.sv @@
// Top level of the shunting-yard infix to postfix converter.
//
//   channel  | valid        | stall        | word
//   ---------+--------------+--------------+---------------------------------
//   item     | item_valid   | item_stall   | item   (in_char, end_of_expr)
//   result   | result_valid | result_stall | result (out_char, last, status)
//
// Sequence: one word is taken at a time, in the idle state. A letter, digit
// or unmatched ')' passes dispatch and finish, a push dispatch, push and
// finish, a flush of an empty stack dispatch alone. Every stack entry looked
// at (popped, the dropped '(' or the entry that stops an operator) adds a
// memory read of the top, then a compare: the stack memory has a registered read.
// Reset: rst clears the sequencer, the output and the stack count; the stack
// memory itself is not cleared, entries above the count are never read.
// Stalls: a held result waits while the output register is full and stalled,
// and the sequencer, and so item_stall, waits with it.
module infix_to_postfix_converter_core import ifp_pkg::*; #(
  parameter int unsigned STACK_DEPTH = DEF_STACK_DEPTH
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      item_valid,
  output logic      item_stall,
  input  in_word_t  item,
  output logic      result_valid,
  input  logic      result_stall,
  output out_word_t result
);

  state_t     state, state_next;
  in_word_t   cur;

  // one result is held back until we know whether another follows it,
  // so that last can be set on the final one
  logic       pend_valid, pend_valid_next;
  logic [7:0] pend_char, pend_char_next;
  status_t    pend_status, pend_status_next;

  logic       out_load;
  logic       out_last;
  logic       out_free;

  stk_ctrl_t  stk_ctrl;
  stk_stat_t  stk_stat;
  logic [7:0] top_char;

  logic       can_move;
  logic       stop_here;

  ifp_stack #(
    .STACK_DEPTH(STACK_DEPTH)
  ) u_stack (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (stk_ctrl),
    .push_char (cur.in_char),
    .top_char  (top_char),
    .stat      (stk_stat)
  );

  assign item_stall = (state != ST_IDLE);
  assign out_free   = !result_valid || !result_stall;
  assign can_move   = !pend_valid || out_free;

  // operator pop loop halts at '(' or at a lower-priority entry
  assign stop_here  = (top_char == CH_LPAREN) || (op_prio(top_char) < op_prio(cur.in_char));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next       = state;
    pend_valid_next  = pend_valid;
    pend_char_next   = pend_char;
    pend_status_next = pend_status;
    out_load         = 1'b0;
    out_last         = 1'b0;
    stk_ctrl         = '0;

    case (state)
      ST_IDLE: begin
        if (item_valid) state_next = ST_DISPATCH;
      end

      ST_DISPATCH: begin
        if (cur.end_of_expr) begin
          state_next = stk_stat.empty ? ST_IDLE : ST_READ;
        end else if (cur.in_char == CH_LPAREN) begin
          state_next = ST_PUSH;
        end else if (is_alnum(cur.in_char)) begin
          pend_valid_next  = 1'b1;
          pend_char_next   = cur.in_char;
          pend_status_next = STAT_OK;
          state_next       = ST_FIN;
        end else if (cur.in_char == CH_RPAREN) begin
          if (stk_stat.paren_any) begin
            state_next = ST_READ;
          end else begin
            pend_valid_next  = 1'b1;
            pend_char_next   = CH_NUL;
            pend_status_next = STAT_UNMATCHED;
            state_next       = ST_FIN;
          end
        end else begin
          state_next = stk_stat.empty ? ST_PUSH : ST_READ;
        end
      end

      ST_READ: begin
        state_next = ST_EVAL;
      end

      ST_EVAL: begin
        if (!cur.end_of_expr && cur.in_char == CH_RPAREN && top_char == CH_LPAREN) begin
          // matching '(' is dropped
          stk_ctrl.pop = 1'b1;
          state_next   = ST_FIN;
        end else if (!cur.end_of_expr && cur.in_char != CH_RPAREN && stop_here) begin
          state_next = ST_PUSH;
        end else if (can_move) begin
          stk_ctrl.pop     = 1'b1;
          out_load         = pend_valid;
          pend_valid_next  = 1'b1;
          pend_char_next   = top_char;
          pend_status_next = STAT_OK;
          if (cur.end_of_expr) begin
            state_next = stk_stat.one_left ? ST_FIN : ST_READ;
          end else if (cur.in_char == CH_RPAREN) begin
            state_next = ST_READ;
          end else begin
            state_next = stk_stat.one_left ? ST_PUSH : ST_READ;
          end
        end
      end

      ST_PUSH: begin
        // full only when nothing was popped, so nothing is pending here
        if (stk_stat.full) begin
          pend_valid_next  = 1'b1;
          pend_char_next   = CH_NUL;
          pend_status_next = STAT_OVERFLOW;
        end else begin
          stk_ctrl.push = 1'b1;
        end
        state_next = ST_FIN;
      end

      ST_FIN: begin
        if (!pend_valid) begin
          state_next = ST_IDLE;
        end else if (out_free) begin
          out_load        = 1'b1;
          out_last        = 1'b1;
          pend_valid_next = 1'b0;
          state_next      = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && item_valid) begin
      cur <= item;
    end
    pend_char   <= pend_char_next;
    pend_status <= pend_status_next;
    if (out_load) begin
      result.out_char <= pend_char;
      result.last     <= out_last;
      result.status   <= pend_status;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid   <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      pend_valid <= pend_valid_next;
      if (out_load) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

endmodule
